### hdl/dlcf_pkg.sv
// Shared types and constants of the display-list control-flow unit.
package dlcf_pkg;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_CMD    = 2'd1,
    OP_UPDATE = 2'd2
  } op_t;

  localparam logic [1:0] ST_DRAWING   = 2'd0;
  localparam logic [1:0] ST_STALLING  = 2'd1;
  localparam logic [1:0] ST_COMPLETED = 2'd2;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_BUDGET    = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd2;
  localparam logic [1:0] ERR_UNDERFLOW = 2'd3;

  localparam logic [7:0] CMD_NOP    = 8'h00;
  localparam logic [7:0] CMD_JUMP   = 8'h08;
  localparam logic [7:0] CMD_BJUMP  = 8'h09;
  localparam logic [7:0] CMD_CALL   = 8'h0A;
  localparam logic [7:0] CMD_RET    = 8'h0B;
  localparam logic [7:0] CMD_END    = 8'h0C;
  localparam logic [7:0] CMD_SIGNAL = 8'h0E;
  localparam logic [7:0] CMD_FINISH = 8'h0F;
  localparam logic [7:0] CMD_BASE   = 8'h10;

  localparam logic [23:0] BUDGET_RESET = 24'd2000000;

  typedef struct packed {
    logic [31:0] fetch_addr;
    logic [1:0]  list_state;
    logic [1:0]  error_code;
    logic        forward_valid;
    logic [31:0] forward_word;
    logic [3:0]  forward_base;
    logic        signal_valid;
    logic [23:0] signal_code;
    logic        finish_valid;
    logic [23:0] finish_data;
  } result_t;

endpackage

### hdl/display_list_control_flow.sv
// Top level of the display-list control-flow unit.
// The unit takes one beat per clock cycle while in_ready is high: a start, a
// command word or a stall update is decoded in the cycle it is accepted, and its
// result is registered into a two-entry output buffer (head and skid), so input
// beats keep flowing while one result waits.
// The return stack lives in a RAM whose registered read port always presents the
// entry at the top of the stack before a RET needs it, with a bypass for a CALL in
// the previous cycle, so back-to-back CALL and RET run without a bubble.
// The stack needs no clearing after reset; the command budget register resets to
// 2000000. Write it through the configuration port only while idle (unchecked).
module display_list_control_flow #(
  parameter int STACK_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [23:0] cfg_write_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [31:0] list_addr,
  input  logic [31:0] stall_addr,
  input  logic [31:0] word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] fetch_addr,
  output logic [1:0]  list_state,
  output logic [1:0]  error_code,
  output logic        forward_valid,
  output logic [31:0] forward_word,
  output logic [3:0]  forward_base,
  output logic        signal_valid,
  output logic [23:0] signal_code,
  output logic        finish_valid,
  output logic [23:0] finish_data
);
  import dlcf_pkg::*;

  localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  logic [23:0]    command_budget;
  logic [31:0]    fetch_pointer, fetch_pointer_next;
  logic [3:0]     base_bits, base_bits_next;
  logic [SPW-1:0] stack_pointer, stack_pointer_next;
  logic [23:0]    command_count, command_count_next;
  logic [31:0]    stall_pointer, stall_pointer_next;
  logic [1:0]     run_state, run_state_next;
  logic           finish_seen, finish_seen_next;
  logic [23:0]    finish_payload, finish_payload_next;

  logic           accept;
  logic [1:0]     prior_state;
  logic           do_check;
  result_t        res;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [31:0]    ram_rdata, stack_top;
  logic [SPW-1:0] sp_view;
  logic           bypass_valid;
  logic [31:0]    bypass_data;

  logic [7:0]     cmd_id;
  logic [31:0]    target;

  result_t        head, skid;
  logic           skid_valid;
  logic           pop;

  assign accept    = in_valid && in_ready;
  assign in_ready  = !skid_valid;
  assign pop       = out_valid && out_ready;
  assign cmd_id    = word[31:24];
  assign target    = {4'h0, base_bits, word[23:2], 2'b00};
  assign stack_top = bypass_valid ? bypass_data : ram_rdata;

  always_comb begin
    fetch_pointer_next  = fetch_pointer;
    base_bits_next      = base_bits;
    stack_pointer_next  = stack_pointer;
    command_count_next  = command_count;
    stall_pointer_next  = stall_pointer;
    run_state_next      = run_state;
    finish_seen_next    = finish_seen;
    finish_payload_next = finish_payload;
    prior_state         = run_state;
    do_check            = 1'b0;
    ram_we              = 1'b0;
    res                 = '0;

    case (op)
      OP_START: begin
        stall_pointer_next = stall_addr;
        prior_state        = ST_DRAWING;
        do_check           = 1'b1;
      end
      OP_UPDATE: begin
        stall_pointer_next = stall_addr;
        do_check           = (run_state == ST_STALLING);
      end
      OP_CMD: begin
        if (run_state == ST_DRAWING) begin
          do_check           = 1'b1;
          fetch_pointer_next = fetch_pointer + 32'd4;
          command_count_next = command_count + 24'd1;
          case (cmd_id) inside
            CMD_NOP, CMD_BJUMP: begin
            end
            CMD_BASE: begin
              base_bits_next = word[19:16];
            end
            CMD_JUMP: begin
              fetch_pointer_next = target;
            end
            CMD_CALL: begin
              if (stack_pointer >= SPW'(STACK_DEPTH)) begin
                run_state_next = ST_COMPLETED;
                res.error_code = ERR_OVERFLOW;
              end else begin
                ram_we             = 1'b1;
                stack_pointer_next = stack_pointer + 1'b1;
                fetch_pointer_next = target;
              end
            end
            CMD_RET: begin
              if (stack_pointer == '0) begin
                run_state_next = ST_COMPLETED;
                res.error_code = ERR_UNDERFLOW;
              end else begin
                stack_pointer_next = stack_pointer - 1'b1;
                fetch_pointer_next = stack_top;
              end
            end
            CMD_SIGNAL: begin
              res.signal_valid = 1'b1;
              res.signal_code  = word[23:0];
            end
            CMD_FINISH: begin
              finish_seen_next    = 1'b1;
              finish_payload_next = word[23:0];
            end
            CMD_END: begin
              run_state_next = ST_COMPLETED;
            end
            default: begin
              res.forward_valid = 1'b1;
              res.forward_word  = word;
              res.forward_base  = base_bits;
            end
          endcase
        end
      end
      default: begin
      end
    endcase

    // A start or a resume begins a fresh run from a clean context.
    if (op == OP_START || (op == OP_UPDATE && run_state == ST_STALLING)) begin
      fetch_pointer_next  = (op == OP_START) ? list_addr : fetch_pointer;
      base_bits_next      = '0;
      stack_pointer_next  = '0;
      command_count_next  = '0;
      finish_seen_next    = 1'b0;
      finish_payload_next = '0;
      run_state_next      = ST_DRAWING;
    end

    // The stall test comes before the budget test.
    if (do_check && res.error_code == ERR_NONE && run_state_next == ST_DRAWING) begin
      if (stall_pointer_next != '0 && fetch_pointer_next == stall_pointer_next) begin
        run_state_next = ST_STALLING;
      end else if (command_count_next >= command_budget) begin
        run_state_next = ST_COMPLETED;
        res.error_code = ERR_BUDGET;
      end
    end

    res.fetch_addr   = fetch_pointer_next;
    res.list_state   = run_state_next;
    res.finish_valid = (prior_state != ST_COMPLETED) && (run_state_next == ST_COMPLETED) &&
                       finish_seen_next;
    res.finish_data  = finish_payload_next;
  end

  assign ram_waddr = stack_pointer[AW-1:0];
  assign sp_view   = accept ? stack_pointer_next : stack_pointer;
  assign ram_raddr = (sp_view == '0) ? '0 : AW'(sp_view - 1'b1);

  dlcf_ram #(
    .WIDTH (32),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we && accept),
    .waddr (ram_waddr),
    .wdata (fetch_pointer + 32'd4),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      command_budget <= BUDGET_RESET;
      fetch_pointer  <= '0;
      base_bits      <= '0;
      stack_pointer  <= '0;
      command_count  <= '0;
      stall_pointer  <= '0;
      run_state      <= ST_COMPLETED;
      finish_seen    <= 1'b0;
      finish_payload <= '0;
      bypass_valid   <= 1'b0;
      out_valid      <= 1'b0;
      skid_valid     <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        command_budget <= cfg_write_data;
      end
      if (accept) begin
        fetch_pointer  <= fetch_pointer_next;
        base_bits      <= base_bits_next;
        stack_pointer  <= stack_pointer_next;
        command_count  <= command_count_next;
        stall_pointer  <= stall_pointer_next;
        run_state      <= run_state_next;
        finish_seen    <= finish_seen_next;
        finish_payload <= finish_payload_next;
      end
      bypass_valid <= ram_we && accept && (ram_waddr == ram_raddr);
      if (pop) begin
        if (skid_valid) begin
          skid_valid <= 1'b0;
        end else if (!accept) begin
          out_valid <= 1'b0;
        end
      end else if (accept) begin
        if (!out_valid) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    bypass_data <= fetch_pointer + 32'd4;
    if (pop) begin
      if (skid_valid) begin
        head <= skid;
      end else if (accept) begin
        head <= res;
      end
    end else if (accept) begin
      if (!out_valid) begin
        head <= res;
      end else begin
        skid <= res;
      end
    end
  end

  assign fetch_addr    = head.fetch_addr;
  assign list_state    = head.list_state;
  assign error_code    = head.error_code;
  assign forward_valid = head.forward_valid;
  assign forward_word  = head.forward_word;
  assign forward_base  = head.forward_base;
  assign signal_valid  = head.signal_valid;
  assign signal_code   = head.signal_code;
  assign finish_valid  = head.finish_valid;
  assign finish_data   = head.finish_data;

endmodule

### hdl/dlcf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module dlcf_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/dlcf_checker.sv
// Port-level assertions for the display-list control-flow unit and their bind.
module dlcf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] fetch_addr,
  input logic [1:0]  list_state,
  input logic [1:0]  error_code,
  input logic        forward_valid,
  input logic        signal_valid,
  input logic        finish_valid
);
  import dlcf_pkg::*;

  // Input is refused only while results are backed up at the output.
  assert property (@(posedge clk) disable iff (rst) !in_ready |-> out_valid)
    else $error("input refused with an empty output buffer");

  assert property (@(posedge clk) disable iff (rst)
      out_valid |-> !(forward_valid && signal_valid))
    else $error("one beat both forwarded and signaled");

  assert property (@(posedge clk) disable iff (rst)
      out_valid && (error_code != ERR_NONE || finish_valid) |-> list_state == ST_COMPLETED)
    else $error("error or finish reported on a list that is not completed");

  assert property (@(posedge clk) disable iff (rst)
      out_valid && !out_ready |=> out_valid && $stable(fetch_addr))
    else $error("stalled result beat changed");

endmodule

bind display_list_control_flow dlcf_checker u_dlcf_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .fetch_addr    (fetch_addr),
  .list_state    (list_state),
  .error_code    (error_code),
  .forward_valid (forward_valid),
  .signal_valid  (signal_valid),
  .finish_valid  (finish_valid)
);

### tb/dlcf_checker.sv
// Checker for the display-list control-flow unit: predicts every result beat and compares it.
`timescale 1ns / 100ps
module tb_dlcf_checker #(
  parameter int STACK_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [23:0] cfg_write_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  op,
  input  logic [31:0] list_addr,
  input  logic [31:0] stall_addr,
  input  logic [31:0] word,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] fetch_addr,
  input  logic [1:0]  list_state,
  input  logic [1:0]  error_code,
  input  logic        forward_valid,
  input  logic [31:0] forward_word,
  input  logic [3:0]  forward_base,
  input  logic        signal_valid,
  input  logic [23:0] signal_code,
  input  logic        finish_valid,
  input  logic [23:0] finish_data,
  output int          fail_count,
  output int          pending
);
  import dlcf_pkg::*;

  logic [23:0] budget_q;
  logic [31:0] ptr_q;
  logic [3:0]  base_q;
  logic [31:0] ret_stack [STACK_DEPTH];
  int          depth_q;
  logic [23:0] count_q;
  logic [31:0] stall_q;
  logic [1:0]  state_q;
  logic        fin_seen_q;
  logic [23:0] fin_code_q;

  result_t     expected_status [$];

  int unsigned beats_checked;
  int unsigned forwards_seen;
  int unsigned signals_seen;
  int unsigned finishes_seen;
  int unsigned stalls_seen;
  int unsigned list_errors [4];

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    fail_count++;
    if (fail_count <= 40) begin
      $display("%0t: beat %0d: %s is %h, predicted %h", $time, beats_checked, what, got, want);
    end
  endtask

  function automatic void reset_predictor();
    budget_q   = BUDGET_RESET;
    ptr_q      = '0;
    base_q     = '0;
    depth_q    = 0;
    count_q    = '0;
    stall_q    = '0;
    state_q    = ST_COMPLETED;
    fin_seen_q = 1'b0;
    fin_code_q = '0;
  endfunction

  function automatic logic [1:0] test_stall_and_budget();
    if (state_q != ST_DRAWING) return ERR_NONE;
    if (stall_q != 32'h0 && ptr_q == stall_q) begin
      state_q = ST_STALLING;
      return ERR_NONE;
    end
    if (count_q >= budget_q) begin
      state_q = ST_COMPLETED;
      return ERR_BUDGET;
    end
    return ERR_NONE;
  endfunction

  function automatic logic [1:0] restart_list(logic [31:0] addr);
    ptr_q      = addr;
    base_q     = '0;
    depth_q    = 0;
    count_q    = '0;
    fin_seen_q = 1'b0;
    fin_code_q = '0;
    state_q    = ST_DRAWING;
    return test_stall_and_budget();
  endfunction

  function automatic result_t predict_beat(logic [1:0] beat_op, logic [31:0] la,
                                           logic [31:0] sa, logic [31:0] w);
    result_t     r;
    logic [1:0]  prior;
    logic [1:0]  entry_state;
    logic [31:0] target;
    r           = '0;
    prior       = state_q;
    entry_state = state_q;
    target      = {4'h0, base_q, w[23:2], 2'b00};
    case (beat_op)
      OP_START: begin
        stall_q      = sa;
        prior        = ST_DRAWING;
        r.error_code = restart_list(la);
      end
      OP_UPDATE: begin
        stall_q = sa;
        if (state_q == ST_STALLING) r.error_code = restart_list(ptr_q);
      end
      OP_CMD: begin
        if (state_q == ST_DRAWING) begin
          ptr_q   = ptr_q + 32'd4;
          count_q = count_q + 24'd1;
          case (w[31:24]) inside
            CMD_NOP, CMD_BJUMP: begin
            end
            CMD_BASE: base_q = w[19:16];
            CMD_JUMP: ptr_q = target;
            CMD_CALL: begin
              if (depth_q >= STACK_DEPTH) begin
                state_q      = ST_COMPLETED;
                r.error_code = ERR_OVERFLOW;
              end else begin
                ret_stack[depth_q] = ptr_q;
                depth_q++;
                ptr_q = target;
              end
            end
            CMD_RET: begin
              if (depth_q == 0) begin
                state_q      = ST_COMPLETED;
                r.error_code = ERR_UNDERFLOW;
              end else begin
                depth_q--;
                ptr_q = ret_stack[depth_q];
              end
            end
            CMD_SIGNAL: begin
              r.signal_valid = 1'b1;
              r.signal_code  = w[23:0];
            end
            CMD_FINISH: begin
              fin_seen_q = 1'b1;
              fin_code_q = w[23:0];
            end
            CMD_END: state_q = ST_COMPLETED;
            default: begin
              r.forward_valid = 1'b1;
              r.forward_word  = w;
              r.forward_base  = base_q;
            end
          endcase
          if (r.error_code == ERR_NONE) r.error_code = test_stall_and_budget();
        end
      end
      default: begin
      end
    endcase
    r.fetch_addr   = ptr_q;
    r.list_state   = state_q;
    r.finish_valid = prior != ST_COMPLETED && state_q == ST_COMPLETED && fin_seen_q;
    r.finish_data  = fin_code_q;
    if (r.forward_valid) forwards_seen++;
    if (r.signal_valid) signals_seen++;
    if (r.finish_valid) finishes_seen++;
    if (r.error_code != ERR_NONE) list_errors[r.error_code]++;
    if (entry_state != ST_STALLING && state_q == ST_STALLING) stalls_seen++;
    return r;
  endfunction

  task automatic compare_status(result_t seen, result_t want);
    beats_checked++;
    if (seen.fetch_addr !== want.fetch_addr)
      report_mismatch("fetch_addr", seen.fetch_addr, want.fetch_addr);
    if (seen.list_state !== want.list_state)
      report_mismatch("list_state", 32'(seen.list_state), 32'(want.list_state));
    if (seen.error_code !== want.error_code)
      report_mismatch("error_code", 32'(seen.error_code), 32'(want.error_code));
    if (seen.forward_valid !== want.forward_valid)
      report_mismatch("forward_valid", 32'(seen.forward_valid), 32'(want.forward_valid));
    if (seen.forward_word !== want.forward_word)
      report_mismatch("forward_word", seen.forward_word, want.forward_word);
    if (seen.forward_base !== want.forward_base)
      report_mismatch("forward_base", 32'(seen.forward_base), 32'(want.forward_base));
    if (seen.signal_valid !== want.signal_valid)
      report_mismatch("signal_valid", 32'(seen.signal_valid), 32'(want.signal_valid));
    if (seen.signal_code !== want.signal_code)
      report_mismatch("signal_code", 32'(seen.signal_code), 32'(want.signal_code));
    if (seen.finish_valid !== want.finish_valid)
      report_mismatch("finish_valid", 32'(seen.finish_valid), 32'(want.finish_valid));
    if (seen.finish_data !== want.finish_data)
      report_mismatch("finish_data", 32'(seen.finish_data), 32'(want.finish_data));
  endtask

  function automatic void show_coverage();
    $display("Checked %0d result beats: %0d forwarded commands, %0d signals, %0d finishes, %0d stalls.",
             beats_checked, forwards_seen, signals_seen, finishes_seen, stalls_seen);
    $display("Lists ended by error: %0d over budget, %0d stack overflow, %0d return underflow.",
             list_errors[ERR_BUDGET], list_errors[ERR_OVERFLOW], list_errors[ERR_UNDERFLOW]);
  endfunction

  always @(posedge clk) begin
    result_t seen;
    result_t want;
    if (rst) begin
      reset_predictor();
      expected_status.delete();
      fail_count = 0;
    end else begin
      if (cfg_write_en) budget_q = cfg_write_data;
      if (in_valid && in_ready) begin
        expected_status.push_back(predict_beat(op, list_addr, stall_addr, word));
      end
      if (out_valid && out_ready) begin
        seen = {fetch_addr, list_state, error_code, forward_valid, forward_word, forward_base,
                signal_valid, signal_code, finish_valid, finish_data};
        if (expected_status.size() == 0) begin
          report_mismatch("result beat with nothing predicted, fetch_addr", seen.fetch_addr,
                          32'h0);
        end else begin
          want = expected_status.pop_front();
          compare_status(seen, want);
        end
      end
    end
    pending <= expected_status.size();
  end

endmodule

### tb/tb_display_list_control_flow.sv
// Testbench top for the display-list control-flow unit: stimulus, flow control and verdict.
`timescale 1ns / 100ps
module tb_display_list_control_flow;
  import dlcf_pkg::*;

  localparam int         STACK_DEPTH = 32;
  localparam int         CYCLE_LIMIT = 300000;
  localparam logic [1:0] OP_UNUSED   = 2'd3;

  logic        clk;
  logic        rst;
  logic        cfg_write_en;
  logic [23:0] cfg_write_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  op;
  logic [31:0] list_addr;
  logic [31:0] stall_addr;
  logic [31:0] word;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] fetch_addr;
  logic [1:0]  list_state;
  logic [1:0]  error_code;
  logic        forward_valid;
  logic [31:0] forward_word;
  logic [3:0]  forward_base;
  logic        signal_valid;
  logic [23:0] signal_code;
  logic        finish_valid;
  logic [23:0] finish_data;
  int          fail_count;
  int          pending;

  int          items_sent;
  int          idle_pct;
  int          cycle_count;
  bit          pressure_armed = 1'b0;
  bit          pressure_served = 1'b0;

  display_list_control_flow #(.STACK_DEPTH(STACK_DEPTH)) i_dut (.*);

  tb_dlcf_checker #(.STACK_DEPTH(STACK_DEPTH)) i_checker (.*);

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit is_flow_id(logic [7:0] id);
    case (id) inside
      CMD_NOP, CMD_JUMP, CMD_BJUMP, CMD_CALL, CMD_RET, CMD_END, CMD_SIGNAL, CMD_FINISH,
      CMD_BASE: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [7:0] render_id();
    logic [7:0] id;
    id = 8'($urandom);
    while (is_flow_id(id)) id = 8'($urandom);
    return id;
  endfunction

  function automatic logic [23:0] rand24();
    return 24'($urandom);
  endfunction

  task automatic send_beat(logic [1:0] beat_op, logic [31:0] la, logic [31:0] sa,
                           logic [31:0] w);
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    op         <= beat_op;
    list_addr  <= la;
    stall_addr <= sa;
    word       <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (beat_op != OP_UNUSED) items_sent++;
  endtask

  task automatic send_cmd(logic [7:0] id, logic [23:0] payload);
    send_beat(OP_CMD, $urandom, $urandom, {id, payload});
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_budget(logic [23:0] value);
    drain();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
  endtask

  task automatic run_episode();
    logic [31:0] start_a;
    logic [31:0] stall_a;
    int          len;
    int          depth;
    int          pick;
    int          kind;
    start_a = $urandom;
    if ($urandom_range(0, 3) != 0) start_a[1:0] = 2'b00;
    len  = $urandom_range(2, 24);
    kind = $urandom_range(0, 19);
    if (kind < 4) begin
      // Straight-line list that stalls, resumes into a second stall, then ends.
      stall_a = start_a + 4 * $urandom_range(1, len);
      send_beat(OP_START, start_a, stall_a, $urandom);
      repeat (len + 2) send_cmd($urandom_range(0, 1) ? CMD_NOP : render_id(), rand24());
      stall_a = stall_a + 4 * $urandom_range(1, 4);
      send_beat(OP_UPDATE, $urandom, stall_a, $urandom);
      repeat (5) send_cmd($urandom_range(0, 1) ? CMD_BJUMP : render_id(), rand24());
      send_beat(OP_UPDATE, $urandom, 32'h0, $urandom);
      send_cmd(CMD_END, rand24());
    end else if (kind == 4) begin
      send_beat(OP_START, start_a, 32'h0, $urandom);
      repeat (STACK_DEPTH + $urandom_range(1, 3)) send_cmd(CMD_CALL, rand24());
    end else begin
      case ($urandom_range(0, 3))
        0: stall_a = start_a + 4 * $urandom_range(1, len);
        1: stall_a = $urandom;
        default: stall_a = 32'h0;
      endcase
      send_beat(OP_START, start_a, stall_a, $urandom);
      depth = 0;
      repeat (len) begin
        pick = $urandom_range(0, 99);
        if (pick < 28) begin
          send_cmd(render_id(), rand24());
        end else if (pick < 36) begin
          send_cmd($urandom_range(0, 1) ? CMD_NOP : CMD_BJUMP, rand24());
        end else if (pick < 43) begin
          send_cmd(CMD_BASE, rand24());
        end else if (pick < 49) begin
          send_cmd(CMD_JUMP, rand24());
        end else if (pick < 63) begin
          send_cmd(CMD_CALL, rand24());
          depth++;
        end else if (pick < 77) begin
          if (depth > 0 || $urandom_range(0, 9) == 0) begin
            send_cmd(CMD_RET, rand24());
            if (depth > 0) depth--;
          end else begin
            send_cmd(CMD_NOP, rand24());
          end
        end else if (pick < 83) begin
          send_cmd(CMD_SIGNAL, rand24());
        end else if (pick < 89) begin
          send_cmd(CMD_FINISH, rand24());
        end else if (pick < 93) begin
          send_beat(OP_UPDATE, $urandom, $urandom_range(0, 1) ? 32'h0 : $urandom, $urandom);
        end else if (pick < 96) begin
          send_beat(OP_UNUSED, $urandom, $urandom, $urandom);
        end else begin
          send_beat(OP_CMD, $urandom, $urandom, $urandom);
        end
      end
      if ($urandom_range(0, 1) == 0) send_beat(OP_UPDATE, $urandom, 32'h0, $urandom);
      if ($urandom_range(0, 3) != 0) send_cmd(CMD_END, rand24());
    end
  endtask

  // Result side: random stalls, plus one long hold-off so the block backs up its input.
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (pressure_armed && !pressure_served) begin
        out_ready <= 1'b0;
        repeat (64) @(posedge clk);
        pressure_served = 1'b1;
      end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d result beats outstanding.",
             cycle_count, pending);
    $display("display_list_control_flow: mismatch");
    $finish;
  end

  initial begin
    int phase_end;
    rst            = 1'b1;
    cfg_write_en   = 1'b0;
    cfg_write_data = '0;
    in_valid       = 1'b0;
    op             = OP_START;
    list_addr      = '0;
    stall_addr     = '0;
    word           = '0;
    items_sent     = 0;
    idle_pct       = 30;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Before any start the list is complete, so commands and odd ops change nothing.
    send_cmd(CMD_END, 24'h000000);
    send_beat(OP_UNUSED, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_beat(OP_UPDATE, 32'h0, 32'hFFFFFFFF, 32'h0);
    send_beat(OP_START, 32'h00001000, 32'h0, 32'h0);
    send_cmd(CMD_NOP, 24'h000000);
    send_cmd(CMD_BJUMP, 24'hFFFFFF);
    send_cmd(8'hFF, 24'hFFFFFF);
    send_cmd(CMD_BASE, 24'h0F0000);
    send_cmd(8'h01, 24'h000000);
    send_cmd(CMD_JUMP, 24'hFFFFFF);
    send_cmd(CMD_CALL, 24'h000100);
    send_cmd(CMD_RET, 24'h000000);
    send_cmd(CMD_RET, 24'h000000);
    send_beat(OP_START, 32'h00002000, 32'h00002000, 32'h0);
    send_beat(OP_UPDATE, 32'h0, 32'h0, 32'h0);
    send_cmd(CMD_SIGNAL, 24'hFFFFFF);
    send_cmd(CMD_FINISH, 24'h123456);
    send_cmd(CMD_END, 24'h000000);
    send_beat(OP_START, 32'hFFFFFFFC, 32'h00000004, 32'h0);
    send_cmd(CMD_NOP, 24'h000000);
    send_cmd(CMD_NOP, 24'h000000);
    send_cmd(8'h20, 24'hABCDEF);
    send_beat(OP_UPDATE, 32'h0, 32'h0, 32'h0);
    send_cmd(CMD_END, 24'h000000);

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        1: set_budget(24'hFFFFFF);
        2: set_budget(24'd1);
        3: set_budget(24'($urandom_range(5, 40)));
        4: set_budget(24'($urandom_range(1000, 100000)));
        5: set_budget(24'($urandom_range(5, 60)));
        default: begin
        end
      endcase
      idle_pct = (phase == 2 || phase == 5) ? 0 : 20 + 10 * (phase % 3);
      if (phase == 1) pressure_armed = 1'b1;
      phase_end = items_sent + ((phase == 2) ? 120 : ((phase == 5) ? 340 : 240));
      while (items_sent < phase_end) run_episode();
    end

    drain();
    i_checker.show_coverage();
    if (fail_count == 0) begin
      $display("display_list_control_flow: match");
    end else begin
      $display("display_list_control_flow: mismatch");
    end
    $finish;
  end

endmodule
